// ===== hw/rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation block: controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_RUN,
        S_SQ_RUN,
        S_MUL_RUN,
        S_FINISH
    } t_state;

    typedef enum logic {
        OP_SQUARE,
        OP_MULT
    } t_op_sel;

    typedef struct packed {
        logic    load;
        logic    start;
        t_op_sel op_sel;
        logic    step;
        logic    base_wr;
        logic    acc_wr;
        logic    exp_shift;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_mod_zero;
        logic exp_msb;
    } t_dp_status;

endpackage

// ===== hw/rtl/mexp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, a shared bit-serial modular multiply step,
// the running power, the reduced base and the result register.
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [OPERAND_WIDTH-1:0] i_base,
    input  logic [OPERAND_WIDTH-1:0] i_exp,
    input  logic [OPERAND_WIDTH-1:0] i_mod,
    input  mexp_pkg::t_dp_cmd        i_cmd,
    output mexp_pkg::t_dp_status     o_status,
    output logic [OPERAND_WIDTH-1:0] o_result
);
    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int TW = W + 3;

    logic [W-1:0]  r_mod;
    logic [W-1:0]  r_exp;
    logic [W-1:0]  r_base;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_prod;
    logic [W-1:0]  r_mx;
    logic [W-1:0]  r_my;
    logic [W-1:0]  r_out;
    logic [TW-1:0] w_sum;
    logic [TW-1:0] w_d1;
    logic [TW-1:0] w_d2;
    logic [W-1:0]  n_prod;
    logic [W-1:0]  w_acc_fwd;

    // One step computes (2 * prod + ybit * x) mod m; the sum stays below 3m.
    always_comb begin
        w_sum = {2'b00, r_prod, 1'b0} + (r_my[W-1] ? {3'b000, r_mx} : {TW{1'b0}});
        w_d1  = w_sum - {3'b000, r_mod};
        w_d2  = w_sum - {2'b00, r_mod, 1'b0};
        if (!w_d2[TW-1]) begin
            n_prod = w_d2[W-1:0];
        end else if (!w_d1[TW-1]) begin
            n_prod = w_d1[W-1:0];
        end else begin
            n_prod = w_sum[W-1:0];
        end
    end

    assign w_acc_fwd = i_cmd.acc_wr ? n_prod : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod  <= i_mod;
            r_exp  <= i_exp;
            r_mx   <= W'(1);
            r_my   <= i_base;
            r_prod <= '0;
            r_acc  <= (i_mod > W'(1)) ? W'(1) : '0;
        end else begin
            if (i_cmd.start) begin
                r_prod <= '0;
                r_mx   <= w_acc_fwd;
                r_my   <= (i_cmd.op_sel == OP_MULT) ? r_base : w_acc_fwd;
            end else if (i_cmd.step) begin
                r_prod <= n_prod;
                r_my   <= {r_my[W-2:0], 1'b0};
            end
            if (i_cmd.acc_wr) begin
                r_acc <= n_prod;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {r_exp[W-2:0], 1'b0};
            end
        end
        if (i_cmd.base_wr) begin
            r_base <= n_prod;
        end
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    assign o_status.in_mod_zero = (i_mod == '0);
    assign o_status.exp_msb     = r_exp[W-1];
    assign o_result             = r_out;

`ifndef ASSERT_OFF
    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && (r_mod != '0)) |-> (r_prod < r_mod))
        else $error("partial product not reduced below the modulus");

    a_mult_operand_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && (i_cmd.op_sel == OP_MULT)) |-> (r_base < r_mod))
        else $error("reduced base not below the modulus at multiply start");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && (r_mod != '0)) |-> (r_acc < r_mod))
        else $error("result not below the modulus");
`endif

endmodule

// ===== hw/rtl/mexp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction, squaring and multiplication over the
// exponent bits, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  mexp_pkg::t_dp_status i_status,
    output mexp_pkg::t_dp_cmd    o_cmd
);
    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_step_cnt;
    logic [CW-1:0] n_step_cnt;
    logic [CW-1:0] r_exp_cnt;
    logic [CW-1:0] n_exp_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          w_accept;
    logic          w_step_last;
    logic          w_exp_last;
    logic          w_out_free;

    assign w_accept    = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_step_last = (r_step_cnt == CW'(W - 1));
    assign w_exp_last  = (r_exp_cnt == CW'(W - 1));
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.in_mod_zero ? S_FINISH : S_RED_RUN;
                end
            end
            S_RED_RUN: begin
                if (w_step_last) begin
                    n_state = S_SQ_RUN;
                end
            end
            S_SQ_RUN: begin
                if (w_step_last) begin
                    if (i_status.exp_msb) begin
                        n_state = S_MUL_RUN;
                    end else if (w_exp_last) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_MUL_RUN: begin
                if (w_step_last) begin
                    n_state = w_exp_last ? S_FINISH : S_SQ_RUN;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.op_sel    = OP_SQUARE;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = w_accept;
            end
            S_RED_RUN: begin
                o_cmd.step = 1'b1;
                if (w_step_last) begin
                    o_cmd.base_wr = 1'b1;
                    o_cmd.start   = 1'b1;
                end
            end
            S_SQ_RUN: begin
                o_cmd.step = 1'b1;
                if (w_step_last) begin
                    o_cmd.acc_wr = 1'b1;
                    if (i_status.exp_msb) begin
                        o_cmd.start  = 1'b1;
                        o_cmd.op_sel = OP_MULT;
                    end else begin
                        o_cmd.exp_shift = 1'b1;
                        o_cmd.start     = !w_exp_last;
                    end
                end
            end
            S_MUL_RUN: begin
                o_cmd.step = 1'b1;
                if (w_step_last) begin
                    o_cmd.acc_wr    = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                    o_cmd.start     = !w_exp_last;
                end
            end
            S_FINISH: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_step_cnt = r_step_cnt;
        n_exp_cnt  = r_exp_cnt;
        if (o_cmd.load || o_cmd.start) begin
            n_step_cnt = '0;
        end else if (o_cmd.step) begin
            n_step_cnt = r_step_cnt + CW'(1);
        end
        if (o_cmd.load) begin
            n_exp_cnt = '0;
        end else if (o_cmd.exp_shift) begin
            n_exp_cnt = r_exp_cnt + CW'(1);
        end
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cnt  <= '0;
            r_exp_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step_cnt  <= n_step_cnt;
            r_exp_cnt   <= n_exp_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

`ifndef ASSERT_OFF
    a_start_at_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (o_cmd.step && w_step_last))
        else $error("multiply started before the previous run ended");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("pending result overwritten");

    a_exp_shift_at_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exp_shift |-> w_step_last)
        else $error("exponent bit consumed mid-run");

    a_finish_after_all_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && (r_state != S_FINISH) && (n_state == S_FINISH))
            |-> w_exp_last)
        else $error("finished before all exponent bits were processed");
`endif

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// One item is in work at a time; the single bit-serial modular multiply step takes one
// multiplier bit a cycle. The next transfer can be taken in the cycle after the result is
// loaded. A zero modulus goes straight to the finish state and returns 0 without any multiply runs.
// Synchronous active-low reset returns to idle and drops any pending result.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply modular exponentiation on a stream interface.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32,
    localparam int IN_W  = ((3 * OPERAND_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // base_value, exponent_value, modulus_value
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // power_result
    output logic [OUT_W-1:0] m_axis_tdata
);
    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [W-1:0] w_result;

    mexp_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    mexp_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_base   (s_axis_tdata[W-1:0]),
        .i_exp    (s_axis_tdata[2*W-1:W]),
        .i_mod    (s_axis_tdata[3*W-1:2*W]),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign m_axis_tdata = OUT_W'(w_result);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modular exponentiation block. A short table of
// hand-picked operands is sent first, then a few hundred random requests with
// biased operands. Each result is checked against its row's typed result or a
// bit-serial square-and-multiply predictor; both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WIDTH         = 32;
    localparam int RANDOM_ITEMS  = 270;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int DIRECTED_ROWS = 23;

    typedef logic [WIDTH-1:0] t_operand;

    typedef struct packed {
        t_operand base;
        t_operand expo;
        t_operand modulus;
        logic     typed;
        t_operand power;
    } t_power_case;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [3*WIDTH-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [WIDTH-1:0]   m_axis_tdata;

    t_operand pending_powers[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       ready_hold     = 0;
    int       ready_percent  = 100;

    // Rows with typed set carry a result that follows directly from the operands.
    t_power_case directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_1234, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'h0000_0001},
        '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'h0000_000A, 32'h0000_0001, 32'h0000_0007, 1'b1, 32'h0000_0003},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0010, 1'b1, 32'h0000_000F},
        '{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0005, 32'h0000_000D, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'h0000_0002, 32'h0000_000A, 32'h0000_2717, 1'b1, 32'h0000_0400},
        '{32'h0000_0003, 32'h0000_0004, 32'h0000_0064, 1'b1, 32'h0000_0051},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001},
        '{32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
        '{32'h0000_0002, 32'h0000_0020, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'h0000_0005, 32'hFFFF_FFFA, 32'hFFFF_FFFB, 1'b1, 32'h0000_0001},
        '{32'h0000_0003, 32'h0000_0007, 32'h0000_0002, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFB, 1'b1, 32'h0000_0040},
        '{32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001, 1'b0, 32'h0000_0000},
        '{32'hDEAD_BEEF, 32'h5555_5555, 32'hAAAA_AAAB, 1'b0, 32'h0000_0000},
        '{32'h89AB_CDEF, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'h0000_0007, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000}
    };

    modular_exponentiation #(
        .OPERAND_WIDTH(WIDTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] mod_sum(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] m);
        logic [63:0] gap;
        gap = m - y;
        return (x >= gap) ? x - gap : x + y;
    endfunction

    function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y,
                                                input logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            acc = mod_sum(acc, acc, m);
            if (y[i]) begin
                acc = mod_sum(acc, x, m);
            end
        end
        return acc;
    endfunction

    function automatic t_operand power_mod(input t_operand base, input t_operand expo,
                                           input t_operand modulus);
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] acc;
        if (modulus == '0) begin
            return '0;
        end
        m   = {32'h0, modulus};
        b   = {32'h0, base} % m;
        acc = 64'd1 % m;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            acc = mod_product(acc, acc, m);
            if (expo[i]) begin
                acc = mod_product(acc, b, m);
            end
        end
        return acc[WIDTH-1:0];
    endfunction

    // Holds the request on the bus until the transfer, then records its expected power.
    task automatic send_request(input t_operand base, input t_operand expo,
                                input t_operand modulus, input logic typed,
                                input t_operand typed_power);
        s_axis_tdata  <= {modulus, expo, base};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_powers.insert(pending_powers.size(),
                              typed ? typed_power : power_mod(base, expo, modulus));
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results;
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_operand pick_base;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_operand'($urandom_range(0, 15));
            default: return t_operand'($urandom);
        endcase
    endfunction

    function automatic t_operand pick_exponent;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return t_operand'(1);
            2:       return '1;
            3:       return t_operand'($urandom_range(0, 63));
            4:       return t_operand'(1) << $urandom_range(0, WIDTH - 1);
            default: return t_operand'($urandom);
        endcase
    endfunction

    function automatic t_operand pick_modulus;
        t_operand value;
        case ($urandom_range(0, 9))
            0:       value = t_operand'(1);
            1:       value = '1;
            2:       value = t_operand'($urandom_range(1, 255));
            3:       value = t_operand'($urandom) | 32'h8000_0000;
            4:       value = t_operand'($urandom_range(2, 65535));
            default: value = t_operand'($urandom);
        endcase
        return (value == '0) ? t_operand'(1) : value;
    endfunction

    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_hold <= $urandom_range(16, 200);
            case ($urandom_range(0, 3))
                0:       ready_percent <= 100;
                1:       ready_percent <= 75;
                2:       ready_percent <= 30;
                default: ready_percent <= 3;
            endcase
        end else begin
            ready_hold <= ready_hold - 1;
        end
        m_axis_tready <= ($urandom_range(1, 100) <= ready_percent);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_powers.size() == 0) begin
                $display("%0t: result transfer 0x%08h with nothing expected", $time,
                         m_axis_tdata);
                mismatch_count <= mismatch_count + 1;
            end else begin
                if (m_axis_tdata !== pending_powers[0]) begin
                    $display("%0t: power_result expected 0x%08h, actual 0x%08h", $time,
                             pending_powers[0], m_axis_tdata);
                    mismatch_count <= mismatch_count + 1;
                end
                void'(pending_powers.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_powers.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int burst_left;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].base, directed_rows[r].expo,
                         directed_rows[r].modulus, directed_rows[r].typed,
                         directed_rows[r].power);
        end
        hold_off(1);
        wait_for_results();

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0:       hold_off($urandom_range(100, 2500));
                    1, 2:    hold_off(0);
                    default: hold_off($urandom_range(1, 30));
                endcase
                if ($urandom_range(0, 19) == 0) begin
                    hold_off(1);
                    wait_for_results();
                end
            end
            send_request(pick_base(), pick_exponent(), pick_modulus(), 1'b0, '0);
            burst_left--;
        end
        hold_off(1);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== modular_exponentiation.f =====
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_dp.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
test/tb_top.sv
